// File: rtl/imm_pkg.sv
// Shared types and constants of the int8 matrix multiply core.
package imm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam int ELEM_W = 8;
    localparam int PROD_W = 16;
    localparam int ACC_W  = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic in_valid;
    } mac_ctrl_t;

endpackage

// File: rtl/imm_mac.sv
// Shared multiply-accumulate unit: one registered 8x8 product, then a 32-bit accumulate.
module imm_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  imm_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [imm_pkg::ELEM_W-1:0]  a,
    input  logic signed [imm_pkg::ELEM_W-1:0]  b,
    output logic                               pending,
    output logic        [imm_pkg::ACC_W-1:0]   acc
);
    import imm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic        [ACC_W-1:0]  acc_reg;
    logic        [ACC_W-1:0]  acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_valid)
        begin
            prod_reg <= a * b;
        end
        acc_reg <= acc_next;
    end

    // The sum wraps modulo 2^32, as two's complement addition does.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign pending = prod_vld_reg;
    assign acc     = acc_reg;

endmodule

// File: rtl/int8_matrix_multiply_core.sv
// Int8 matrix multiply core with 32-bit accumulation, C = A x B.
//
// Load requests (an A or a B element) give no response.
// A compute request for row r of C emits cols_b sums in column order, the last
// one with tlast set. Every sum is formed by a single shared multiply-accumulate
// unit that takes one product per cycle, fed from one read port on each
// element store. Each column issues inner_len reads, drains the MAC and then
// waits in the emit state while the output is stalled; the core takes no new
// request until the row is done. Loads and computes outside the configured
// sizes are dropped. Stores are not cleared at reset: reading an element that
// was never loaded gives an undefined sum. Sizes above MAX_DIM act as MAX_DIM.
module int8_matrix_multiply_core #(
    parameter int MAX_DIM = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // row[3:0], col[7:4], element[15:8]
    input  logic [1:0]                      s_tuser,   // op[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // out_row[3:0], out_col[7:4], product_sum[39:8]
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        if (int'(v) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(v);
    endfunction

    // Configuration.
    logic [CFG_DATA_W-1:0] rows_a_reg;
    logic [CFG_DATA_W-1:0] inner_len_reg;
    logic [CFG_DATA_W-1:0] cols_b_reg;
    logic [DW-1:0]         m_eff;
    logic [DW-1:0]         n_eff;
    logic [DW-1:0]         o_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_len_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_LEN: inner_len_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign m_eff = clamp_dim(rows_a_reg);
    assign n_eff = clamp_dim(inner_len_reg);
    assign o_eff = clamp_dim(cols_b_reg);

    // Request decode.
    logic [3:0]              in_row;
    logic [3:0]              in_col;
    logic signed [ELEM_W-1:0] in_elem;
    logic                    accept;
    logic                    load_a_ok;
    logic                    load_b_ok;
    logic                    start;
    logic [AW-1:0]           wr_addr;

    assign in_row  = s_tdata[3:0];
    assign in_col  = s_tdata[7:4];
    assign in_elem = s_tdata[15:8];
    assign accept  = s_tvalid && s_tready;

    assign load_a_ok = accept && (s_tuser == OP_LOAD_A)
                       && (DW'(in_row) < m_eff) && (DW'(in_col) < n_eff);
    assign load_b_ok = accept && (s_tuser == OP_LOAD_B)
                       && (DW'(in_row) < n_eff) && (DW'(in_col) < o_eff);
    // A row with no columns emits nothing, so it never leaves idle.
    assign start     = accept && (s_tuser == OP_COMPUTE)
                       && (DW'(in_row) < m_eff) && (o_eff != '0);
    assign wr_addr   = AW'(int'(in_row) * MAX_DIM + int'(in_col));

    // Sequencer state.
    state_t        state_reg;
    state_t        state_next;
    logic [3:0]    row_reg;
    logic [DW-1:0] j_reg;
    logic [DW-1:0] j_next;
    logic [DW-1:0] c_reg;
    logic [DW-1:0] c_next;
    logic          rd_vld_reg;
    logic          rd_en;
    logic          out_free;
    logic          last_col;
    logic          load_out;
    logic          next_col;
    mac_ctrl_t     mac_ctrl;
    logic          mac_pending;
    logic [ACC_W-1:0] mac_acc;

    // Element stores and their read ports.
    logic signed [ELEM_W-1:0] left_store_mem  [DEPTH];
    logic signed [ELEM_W-1:0] right_store_mem [DEPTH];
    logic signed [ELEM_W-1:0] left_q_reg;
    logic signed [ELEM_W-1:0] right_q_reg;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;

    assign rd_a_addr = AW'(int'(row_reg) * MAX_DIM + int'(j_reg));
    assign rd_b_addr = AW'(int'(j_reg) * MAX_DIM + int'(c_reg));

    always_ff @(posedge clk)
    begin
        if (load_a_ok)
        begin
            left_store_mem[wr_addr] <= in_elem;
        end
        if (rd_en)
        begin
            left_q_reg <= left_store_mem[rd_a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b_ok)
        begin
            right_store_mem[wr_addr] <= in_elem;
        end
        if (rd_en)
        begin
            right_q_reg <= right_store_mem[rd_b_addr];
        end
    end

    // Output register.
    logic             m_tvalid_reg;
    logic [3:0]       out_row_reg;
    logic [3:0]       out_col_reg;
    logic [ACC_W-1:0] sum_reg;
    logic             last_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign last_col = (DW'(c_reg + 1'b1) == o_eff);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (j_reg == n_eff)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_pending)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = last_col ? ST_IDLE : ST_ISSUE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready          = 1'b0;
        rd_en             = 1'b0;
        load_out          = 1'b0;
        next_col          = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ISSUE: rd_en    = (j_reg != n_eff);
            ST_DRAIN: ;
            ST_EMIT:
            begin
                load_out = out_free;
                next_col = out_free && !last_col;
            end
            default: ;
        endcase
        mac_ctrl.clear    = start || next_col;
        mac_ctrl.in_valid = rd_vld_reg;
    end

    always_comb
    begin
        j_next = j_reg;
        c_next = c_reg;
        if (start)
        begin
            j_next = '0;
            c_next = '0;
        end
        else if (next_col)
        begin
            j_next = '0;
            c_next = c_reg + 1'b1;
        end
        else if (rd_en)
        begin
            j_next = j_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            j_reg        <= '0;
            c_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            c_reg      <= c_next;
            rd_vld_reg <= rd_en;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= in_row;
        end
        if (load_out)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= c_reg[3:0];
            sum_reg     <= mac_acc;
            last_reg    <= last_col;
        end
    end

    imm_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .a       (left_q_reg),
        .b       (right_q_reg),
        .pending (mac_pending),
        .acc     (mac_acc)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sum_reg, out_col_reg, out_row_reg};
    assign m_tlast  = last_reg;

    // The MAC pipeline must be empty whenever new requests are taken.
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !mac_pending))
        else $error("MAC pipeline busy while idle");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("sum left emit state while output register was stalled");

    a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (j_reg <= n_eff))
        else $error("inner index ran past inner length");

    a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_ISSUE && j_reg == '0 && c_reg == '0))
        else $error("compute request did not start at column zero");

endmodule
